FILE: design/crce_pkg.sv
// shared types and constants for the controller replay command engine
// no dependencies
package crce_pkg;

  typedef enum logic [1:0] {
    MODE_PLAY = 2'd0,
    MODE_REC  = 2'd1,
    MODE_IMM  = 2'd2,
    MODE_STOP = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    RK_HOST  = 3'd0,
    RK_QFILL = 3'd1,
    RK_RFILL = 3'd2,
    RK_ENTRY = 3'd3,
    RK_END   = 3'd4
  } rkind_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_Q, CMD_I, CMD_MREC, CMD_MSTOP, CMD_GQF, CMD_GRF, CMD_SR0, CMD_SRC
  } cmd_t;

  typedef struct packed {
    logic [7:0]  ry;
    logic [7:0]  rx;
    logic [7:0]  ly;
    logic [7:0]  lx;
    logic [7:0]  hat;
    logic [15:0] buttons;
  } report_t;

  localparam report_t NEUTRAL = '{ry: 8'd128, rx: 8'd128, ly: 8'd128, lx: 8'd128,
                                   hat: 8'd8, buttons: 16'd0};

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_RD, ST_RDWAIT, ST_EMIT, ST_END, ST_TICK
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic ld_item;     // latch a new input item
    logic do_exec;     // apply decoded line command / store byte
    logic do_tick;     // apply tick update
    logic rd_issue;    // issue a record read at readout position
    logic rd_adv;      // advance readout position
    logic set_pos0;    // clear readout position
    logic out_load;    // load output register
    rkind_t out_kind;
    logic out_last;
  } ctl_t;

  // datapath -> controller status
  typedef struct packed {
    logic   is_tick;
    logic   is_eol;
    cmd_t   cmd;
    logic   rd_more;   // entries left to read
    logic   out_busy;  // output register holds an item that is not being taken
  } sts_t;

  function automatic logic [4:0] hexval(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

endpackage

FILE: design/crce_ctrl.sv
// sequencing state machine for the command engine
// depends on crce_pkg
module crce_ctrl #(
  parameter int READOUT_BURST = 30
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  crce_pkg::sts_t  sts,
  output crce_pkg::ctl_t  ctl
);
  import crce_pkg::*;

  localparam int BW = $clog2(READOUT_BURST + 1);

  state_t st_r, st_nxt;
  logic [BW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    ctl = '0;
    ctl.out_kind = RK_HOST;
    in_tready = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.ld_item = 1'b1;
          st_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_tick) begin
          st_nxt = ST_TICK;
        end else if (!sts.is_eol) begin
          ctl.do_exec = 1'b1;
          st_nxt = ST_IDLE;
        end else begin
          priority case (sts.cmd)
            CMD_GQF: if (!sts.out_busy) begin
              ctl.out_load = 1'b1; ctl.out_kind = RK_QFILL; ctl.out_last = 1'b1;
              st_nxt = ST_IDLE;
            end
            CMD_GRF: if (!sts.out_busy) begin
              ctl.out_load = 1'b1; ctl.out_kind = RK_RFILL; ctl.out_last = 1'b1;
              st_nxt = ST_IDLE;
            end
            CMD_SR0, CMD_SRC: begin
              ctl.set_pos0 = (sts.cmd == CMD_SR0);
              cnt_nxt = '0;
              st_nxt = ST_RD;
            end
            default: begin
              ctl.do_exec = 1'b1;
              st_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RD: begin
        if (sts.rd_more && cnt_r != BW'(READOUT_BURST)) begin
          ctl.rd_issue = 1'b1;
          st_nxt = ST_RDWAIT;
        end else begin
          st_nxt = ST_END;
        end
      end
      ST_RDWAIT: st_nxt = ST_EMIT;
      ST_EMIT: if (!sts.out_busy) begin
        ctl.out_load = 1'b1; ctl.out_kind = RK_ENTRY;
        ctl.rd_adv = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        st_nxt = ST_RD;
      end
      ST_END: if (!sts.out_busy) begin
        ctl.out_load = 1'b1; ctl.out_kind = RK_END; ctl.out_last = 1'b1;
        st_nxt = ST_IDLE;
      end
      ST_TICK: if (!sts.out_busy) begin
        ctl.do_tick = 1'b1;
        ctl.out_load = 1'b1; ctl.out_kind = RK_HOST; ctl.out_last = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule

FILE: design/crce_dp.sv
// datapath: line buffer, command decode, queue ring, record memory, output register
// depends on crce_pkg
module crce_dp #(
  parameter int QUEUE_DEPTH   = 64,
  parameter int RECORD_DEPTH  = 1024,
  parameter int LINE_CAPACITY = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [8:0]      in_tdata,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  crce_pkg::ctl_t  ctl,
  output crce_pkg::sts_t  sts,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [69:0]     out_tdata,
  output logic [2:0]      out_tuser,
  output logic            out_tlast
);
  import crce_pkg::*;

  localparam int LN = LINE_CAPACITY - 1;
  localparam int LW = $clog2(LINE_CAPACITY);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int CW = $clog2(RECORD_DEPTH + 1);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]    start_r;
  logic          kind_r;
  logic [7:0]    ch_r;
  logic [7:0]    line_r [LN];
  logic [LW-1:0] len_r;
  logic [QW-1:0] qrd_r, qwr_r;
  logic [CW-1:0] rcnt_r, rpos_r;
  mode_t         mode_r;
  report_t       imm_r;
  report_t       qmem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] qvalid_r;
  report_t       qrd_data;
  report_t       rmem [RECORD_DEPTH];
  report_t       rd_data_r;

  // line decode
  logic    hex_ok;
  report_t prs;
  cmd_t    cmd;
  logic [4:0] hv [1:14];
  always_comb begin
    for (int i = 1; i < 15; i++) hv[i] = hexval(line_r[i]);
    hex_ok = (len_r == LW'(15));
    for (int i = 1; i < 15; i++) if (hv[i][4]) hex_ok = 1'b0;
    prs.buttons = {hv[1][3:0], hv[2][3:0], hv[3][3:0], hv[4][3:0]};
    prs.hat = {hv[5][3:0], hv[6][3:0]};
    prs.lx  = {hv[7][3:0], hv[8][3:0]};
    prs.ly  = {hv[9][3:0], hv[10][3:0]};
    prs.rx  = {hv[11][3:0], hv[12][3:0]};
    prs.ry  = {hv[13][3:0], hv[14][3:0]};
    if (line_r[0] == 8'h51 && hex_ok) cmd = CMD_Q;
    else if (line_r[0] == 8'h49 && hex_ok) cmd = CMD_I;
    else if (line_r[0] == 8'h4D && line_r[1] == 8'h52 && line_r[2] == 8'h45 &&
             line_r[3] == 8'h43 && line_r[4] == 8'h00) cmd = CMD_MREC;
    else if (line_r[0] == 8'h4D && line_r[1] == 8'h53 && line_r[2] == 8'h54 &&
             line_r[3] == 8'h4F && line_r[4] == 8'h50 && line_r[5] == 8'h00)
      cmd = CMD_MSTOP;
    else if (line_r[0] == 8'h47 && line_r[1] == 8'h51 && line_r[2] == 8'h46 &&
             line_r[3] == 8'h00) cmd = CMD_GQF;
    else if (line_r[0] == 8'h47 && line_r[1] == 8'h52 && line_r[2] == 8'h46 &&
             line_r[3] == 8'h00) cmd = CMD_GRF;
    else if (line_r[0] == 8'h53 && line_r[1] == 8'h52 && line_r[2] == 8'h30 &&
             line_r[3] == 8'h00) cmd = CMD_SR0;
    else if (line_r[0] == 8'h53 && line_r[1] == 8'h52 && line_r[2] == 8'h43 &&
             line_r[3] == 8'h00) cmd = CMD_SRC;
    else cmd = CMD_NONE;
  end

  logic is_start, is_eol;
  assign is_start = (ch_r == start_r);
  assign is_eol   = !is_start && (ch_r == CH_CR || ch_r == CH_LF);

  logic [QW-1:0] qwr_inc, qrd_inc;
  assign qwr_inc = (QW'(QUEUE_DEPTH - 1) == qwr_r) ? '0 : qwr_r + 1'b1;
  assign qrd_inc = (QW'(QUEUE_DEPTH - 1) == qrd_r) ? '0 : qrd_r + 1'b1;

  logic [QW-1:0] qrd_next;
  assign qrd_next = (qrd_r != qwr_r) ? qrd_inc : qrd_r;

  logic [FW-1:0] qfill;
  assign qfill = (qwr_r >= qrd_r) ? FW'(qwr_r - qrd_r)
               : FW'(QUEUE_DEPTH) - FW'(qrd_r - qwr_r);

  assign sts.is_tick  = kind_r;
  assign sts.is_eol   = is_eol;
  assign sts.cmd      = cmd;
  assign sts.rd_more  = (rpos_r < rcnt_r);
  assign sts.out_busy = out_tvalid && !out_tready;

  // queue ring memory; entries never written read as neutral
  logic qwe;
  assign qwe = ctl.do_exec && !kind_r && is_eol && cmd == CMD_Q;
  always_ff @(posedge clk) begin
    if (qwe) qmem[qwr_inc] <= prs;
    qrd_data <= qmem[qrd_next];
  end
  logic qv_sel_r;
  always_ff @(posedge clk) qv_sel_r <= qvalid_r[qrd_next];

  // record memory
  logic rwe;
  assign rwe = ctl.do_tick && mode_r == MODE_REC && rcnt_r < CW'(RECORD_DEPTH);
  always_ff @(posedge clk) begin
    if (rwe) rmem[rcnt_r[RW-1:0]] <= imm_r;
    if (ctl.rd_issue) rd_data_r <= rmem[rpos_r[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_item) begin
      kind_r <= in_tdata[0];
      ch_r   <= in_tdata[8:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= 8'd43;
      for (int i = 0; i < LN; i++) line_r[i] <= 8'h00;
      len_r    <= '0;
      qrd_r    <= '0;
      qwr_r    <= '0;
      qvalid_r <= '0;
      rcnt_r   <= '0;
      rpos_r   <= '0;
      mode_r   <= MODE_PLAY;
      imm_r    <= NEUTRAL;
    end else begin
      if (cfg_we) start_r <= cfg_wdata;
      if (ctl.do_exec) begin
        if (is_start) begin
          for (int i = 0; i < LN; i++) line_r[i] <= 8'h00;
          len_r <= '0;
        end else if (is_eol) begin
          unique case (cmd)
            CMD_Q: begin
              qwr_r <= qwr_inc;
              qvalid_r[qwr_inc] <= 1'b1;
              mode_r <= MODE_PLAY;
            end
            CMD_I: begin
              imm_r <= prs;
              if (mode_r != MODE_REC) mode_r <= MODE_IMM;
            end
            CMD_MREC: begin
              rcnt_r <= '0;
              mode_r <= MODE_REC;
            end
            CMD_MSTOP: mode_r <= MODE_STOP;
            default: ;
          endcase
        end else if (len_r < LW'(LN)) begin
          line_r[len_r] <= ch_r;
          len_r <= len_r + 1'b1;
        end
      end
      if (ctl.set_pos0) rpos_r <= '0;
      else if (ctl.rd_adv) rpos_r <= rpos_r + 1'b1;
      if (ctl.do_tick) begin
        qrd_r <= qrd_next;
        if (rwe) rcnt_r <= rcnt_r + 1'b1;
      end
    end
  end

  // host report view during a tick, from the updated playing report
  report_t tick_play, show;
  always_comb begin
    if (mode_r == MODE_REC) tick_play = imm_r;
    else tick_play = qv_sel_r ? qrd_data : NEUTRAL;
    unique case (mode_r)
      MODE_IMM:  show = imm_r;
      MODE_STOP: show = NEUTRAL;
      default:   show = tick_play;
    endcase
  end

  // packed result: report 55:0, fill 66:56, more 67, mode 69:68
  logic [69:0] odata_nxt;
  always_comb begin
    odata_nxt = '0;
    odata_nxt[69:68] = mode_r;
    unique case (ctl.out_kind)
      RK_HOST:  odata_nxt[55:0] = show;
      RK_ENTRY: odata_nxt[55:0] = rd_data_r;
      RK_QFILL: odata_nxt[66:56] = 11'(qfill);
      RK_RFILL: odata_nxt[66:56] = 11'(rcnt_r);
      RK_END:   odata_nxt[67] = (rpos_r < rcnt_r);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else begin
      out_tvalid <= ctl.out_load || (out_tvalid && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_tuser <= ctl.out_kind;
      out_tlast <= ctl.out_last;
      out_tdata <= odata_nxt;
    end
  end
endmodule

FILE: design/controller_replay_command_engine.sv
// top level of the controller replay command engine
// depends on crce_pkg, crce_ctrl, crce_dp
//
// usage:
//  in channel: one item per serial byte or frame tick; tdata bit 0 kind,
//  bits 8:1 rx_byte. an item is taken only while the engine is idle.
//  out channel: results held in an output register; tuser is result_kind,
//  tlast marks the final result of the input item.
//  cfg port: cfg_we writes the command start character (reset '+').
//  sequence: a tick passes ST_DECODE and ST_TICK before its result is
//  loaded, a fill query is loaded in ST_DECODE. a readout burst steps
//  through ST_RD, ST_RDWAIT and ST_EMIT for each entry read from the record
//  memory (registered read port), then ST_END; a full burst is 30 entries.
//  pacing: an item is taken only after the current one is done; the next
//  item is taken the cycle after the last result of the current one is loaded.
//  stall: while the receiver holds out_tready low the engine waits with
//  its next result; one result may sit in the output register while the
//  next one is prepared.
//  reset: synchronous, clears line, queue pointers, mode and counters; the
//  queue store reads neutral until each entry is written (valid bits).
module controller_replay_command_engine #(
  parameter int QUEUE_DEPTH   = 64,
  parameter int RECORD_DEPTH  = 1024,
  parameter int LINE_CAPACITY = 32,
  parameter int READOUT_BURST = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // kind, rx_byte
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // buttons, hat, lx, ly, rx, ry, fill_count,
                                  // more_left, play_mode_now
  output logic [2:0]  out_tuser,  // result_kind
  output logic        out_tlast   // last
);
  import crce_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic [69:0] dp_data;

  crce_ctrl #(.READOUT_BURST(READOUT_BURST)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .sts, .ctl
  );

  crce_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .RECORD_DEPTH(RECORD_DEPTH),
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_dp (
    .clk, .rst_n, .in_tdata(in_tdata[8:0]), .cfg_we, .cfg_wdata, .ctl, .sts,
    .out_tvalid, .out_tready, .out_tdata(dp_data), .out_tuser, .out_tlast
  );

  // fields 0..55 report, 56..66 fill, 67 more, 68..69 mode, padded to bytes
  assign out_tdata = {2'b00, dp_data};

  // a tick result is always a final host report
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == RK_HOST) |-> out_tlast)
    else $error("host report not last");
  // no item accepted while a result is being built
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted while busy");
  // entry results never end a burst
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == RK_ENTRY) |-> !out_tlast)
    else $error("entry marked last");
endmodule
